FILE: sv/utp_receive_state_machine_unit_defines.svh
// Assertion macros for the uTP receive block.
// Each macro expects i_clk and i_rst_n in the using module.
`ifndef UTP_RECEIVE_STATE_MACHINE_UNIT_DEFINES_SVH
`define UTP_RECEIVE_STATE_MACHINE_UNIT_DEFINES_SVH

// same-cycle implication
`define UTP_RSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTP_RSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/utp_rsm_pkg.sv
package utp_rsm_pkg;

    localparam logic [3:0] PKT_DATA  = 4'd0;
    localparam logic [3:0] PKT_FIN   = 4'd1;
    localparam logic [3:0] PKT_STATE = 4'd2;
    localparam logic [3:0] PKT_RESET = 4'd3;
    localparam logic [3:0] PKT_SYN   = 4'd4;

    localparam logic [1:0] CFG_CONN_ID   = 2'd0;
    localparam logic [1:0] CFG_OPEN_MODE = 2'd1;
    localparam logic [1:0] CFG_INIT_SEQ  = 2'd2;

    localparam logic [15:0] MIN_PKT_LEN  = 16'd4;
    localparam logic [31:0] RTT_INIT     = 32'd500000;
    localparam logic [31:0] RTT_VAR_INIT = 32'd200000;

    localparam int unsigned S_TDATA_W = 144;
    localparam int unsigned M_TDATA_W = 104;

    // registered header, RTT sample already formed
    typedef struct packed {
        logic [3:0]  pkt_type;
        logic [15:0] pkt_len;
        logic [15:0] conn_id;
        logic [15:0] seq;
        logic        rtt_ok;
        logic [31:0] rtt_sample;
    } t_hdr;

    typedef struct packed {
        logic [31:0] rtt_var;
        logic [31:0] rtt;
        logic        state_changed;
        logic [2:0]  conn_state;
        logic        deliver;
        logic [15:0] own_seq;
        logic [15:0] ack_value;
        logic        send_ack;
    } t_result;

endpackage

FILE: sv/utp_rsm_in_stage.sv
module utp_rsm_in_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [utp_rsm_pkg::S_TDATA_W-1:0]   i_tdata,
    input  logic [3:0]                          i_tuser,
    output logic                                o_valid,
    output utp_rsm_pkg::t_hdr                   o_item,
    input  logic                                i_take
);

    logic              r_valid;
    utp_rsm_pkg::t_hdr r_item;
    utp_rsm_pkg::t_hdr n_item;

    logic [31:0] ts;
    logic [31:0] tdiff;
    logic [31:0] now;

    assign ts    = i_tdata[79:48];
    assign tdiff = i_tdata[111:80];
    assign now   = i_tdata[143:112];

    always_comb begin
        n_item.pkt_type   = i_tuser;
        n_item.pkt_len    = i_tdata[15:0];
        n_item.conn_id    = i_tdata[31:16];
        n_item.seq        = i_tdata[47:32];
        n_item.rtt_ok     = (tdiff != 32'd0) && (now > ts);
        n_item.rtt_sample = (now - ts) + tdiff;
    end

    assign o_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
        if (o_tready && i_tvalid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/utp_rsm_core.sv
`include "utp_receive_state_machine_unit_defines.svh"

module utp_rsm_core #(
    parameter int unsigned HEADER_BYTES = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_valid,
    input  utp_rsm_pkg::t_hdr    i_item,
    output logic                 o_ready,
    output logic                 o_res_valid,
    output utp_rsm_pkg::t_result o_res,
    input  logic                 i_res_ready
);

    localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SYN_SENT  = 3'd1,
        ST_SYN_RECV  = 3'd2,
        ST_CONNECTED = 3'd3,
        ST_CLOSED    = 3'd4
    } t_conn_state;

    t_conn_state r_state, n_state;
    logic [15:0] r_last_ack, n_last_ack;
    logic [15:0] r_own_seq, n_own_seq;
    logic [31:0] r_rtt, n_rtt;
    logic [31:0] r_rtt_var, n_rtt_var;
    logic [15:0] r_cfg_conn_id;
    logic        r_cfg_open;
    logic [15:0] r_cfg_iseq;

    logic                 r_res_valid;
    utp_rsm_pkg::t_result r_res, n_res;

    logic        fire;
    logic        ack, deliver, changed;
    logic [31:0] d, mag, var_sum, est_sum;

    assign o_ready = !r_res_valid || i_res_ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        d       = r_rtt - i_item.rtt_sample;
        mag     = d[31] ? (32'd0 - d) : d;
        var_sum = (r_rtt_var << 1) + r_rtt_var + mag;
        est_sum = (r_rtt << 3) - r_rtt + i_item.rtt_sample;
    end

    always_comb begin
        n_state    = r_state;
        n_last_ack = r_last_ack;
        n_own_seq  = r_own_seq;
        n_rtt      = r_rtt;
        n_rtt_var  = r_rtt_var;
        ack        = 1'b0;
        deliver    = 1'b0;
        changed    = 1'b0;
        if (i_item.pkt_len >= utp_rsm_pkg::MIN_PKT_LEN) begin
            if (i_item.pkt_type == utp_rsm_pkg::PKT_RESET) begin
                n_state = ST_CLOSED;
                changed = 1'b1;
            end else if (i_item.pkt_len >= HDR_LEN && i_item.conn_id == r_cfg_conn_id) begin
                case (i_item.pkt_type)
                    utp_rsm_pkg::PKT_SYN: begin
                        if (r_state == ST_IDLE) begin
                            n_last_ack = i_item.seq;
                            n_state    = ST_SYN_RECV;
                            ack        = 1'b1;
                            changed    = 1'b1;
                        end
                    end
                    utp_rsm_pkg::PKT_STATE: begin
                        if (r_state == ST_SYN_SENT) begin
                            n_last_ack = i_item.seq;
                            n_own_seq  = r_own_seq + 16'd1;
                            n_state    = ST_CONNECTED;
                            changed    = 1'b1;
                        end else if (r_state == ST_SYN_RECV) begin
                            n_last_ack = i_item.seq;
                            n_state    = ST_CONNECTED;
                            changed    = 1'b1;
                        end else if (r_state == ST_CONNECTED) begin
                            if (i_item.seq > r_last_ack) begin
                                n_last_ack = i_item.seq;
                            end
                        end
                        if (i_item.rtt_ok) begin
                            if (r_rtt == utp_rsm_pkg::RTT_INIT) begin
                                n_rtt     = i_item.rtt_sample;
                                n_rtt_var = i_item.rtt_sample >> 1;
                            end else begin
                                n_rtt     = est_sum >> 3;
                                n_rtt_var = var_sum >> 2;
                            end
                        end
                    end
                    utp_rsm_pkg::PKT_DATA: begin
                        if (r_state == ST_CONNECTED || r_state == ST_SYN_RECV) begin
                            if (i_item.seq == r_last_ack + 16'd1) begin
                                n_last_ack = i_item.seq;
                                deliver    = i_item.pkt_len > HDR_LEN;
                                if (r_state == ST_SYN_RECV) begin
                                    n_state = ST_CONNECTED;
                                    changed = 1'b1;
                                end
                                ack = 1'b1;
                            end else if (i_item.seq <= r_last_ack) begin
                                ack = 1'b1;
                            end
                        end
                    end
                    utp_rsm_pkg::PKT_FIN: begin
                        n_state = ST_CLOSED;
                        changed = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        n_res.send_ack      = ack;
        n_res.ack_value     = n_last_ack;
        n_res.own_seq       = n_own_seq;
        n_res.deliver       = deliver;
        n_res.conn_state    = n_state;
        n_res.state_changed = changed;
        n_res.rtt           = n_rtt;
        n_res.rtt_var       = n_rtt_var;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_conn_id <= 16'd0;
            r_cfg_open    <= 1'b0;
            r_cfg_iseq    <= 16'd0;
            r_state       <= ST_IDLE;
            r_last_ack    <= 16'd0;
            r_own_seq     <= 16'd0;
            r_rtt         <= utp_rsm_pkg::RTT_INIT;
            r_rtt_var     <= utp_rsm_pkg::RTT_VAR_INIT;
            r_res_valid   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_res_valid <= i_valid;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    utp_rsm_pkg::CFG_CONN_ID: begin
                        r_cfg_conn_id <= i_cfg_wdata;
                    end
                    utp_rsm_pkg::CFG_OPEN_MODE: begin
                        r_cfg_open <= i_cfg_wdata[0];
                        r_state    <= i_cfg_wdata[0] ? ST_SYN_SENT : ST_IDLE;
                        r_last_ack <= 16'd0;
                        r_own_seq  <= r_cfg_iseq;
                        r_rtt      <= utp_rsm_pkg::RTT_INIT;
                        r_rtt_var  <= utp_rsm_pkg::RTT_VAR_INIT;
                    end
                    utp_rsm_pkg::CFG_INIT_SEQ: begin
                        r_cfg_iseq <= i_cfg_wdata;
                        r_state    <= r_cfg_open ? ST_SYN_SENT : ST_IDLE;
                        r_last_ack <= 16'd0;
                        r_own_seq  <= i_cfg_wdata;
                        r_rtt      <= utp_rsm_pkg::RTT_INIT;
                        r_rtt_var  <= utp_rsm_pkg::RTT_VAR_INIT;
                    end
                    default: ;
                endcase
            end else if (fire) begin
                r_state    <= n_state;
                r_last_ack <= n_last_ack;
                r_own_seq  <= n_own_seq;
                r_rtt      <= n_rtt;
                r_rtt_var  <= n_rtt_var;
            end
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `UTP_RSM_ASSERT_NEXT(a_own_seq_step, fire && !i_cfg_we,
        r_own_seq == $past(r_own_seq) || r_own_seq == $past(r_own_seq) + 16'd1,
        "own sequence moved by more than one")
    `UTP_RSM_ASSERT_IMPL(a_deliver_acks, r_res_valid && r_res.deliver,
        r_res.send_ack && r_res.conn_state == ST_CONNECTED,
        "payload delivered without ack or outside connected")
    `UTP_RSM_ASSERT_IMPL(a_ack_state, r_res_valid && r_res.send_ack,
        r_res.conn_state == ST_SYN_RECV || r_res.conn_state == ST_CONNECTED,
        "ack requested in a state that cannot ack")
    `UTP_RSM_ASSERT_IMPL(a_change_target, r_res_valid && r_res.state_changed,
        r_res.conn_state != ST_IDLE && r_res.conn_state != ST_SYN_SENT,
        "state change into a start state")

endmodule

FILE: sv/utp_receive_state_machine_unit.sv
// A transfer accepted on the input goes through the header register, then the
// result register.
// Throughput: one transfer per cycle when output is ready; state update is one pass.
// Reset (synchronous, active low): configuration cleared, connection idle,
// RTT estimate 500000 and variance 200000; a result still waiting is dropped.
module utp_receive_state_machine_unit #(
    parameter int unsigned HEADER_BYTES = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // packet_length, hdr_conn_id, hdr_seq, hdr_timestamp, hdr_timestamp_diff, now_us
    input  logic [utp_rsm_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // pkt_type
    input  logic [3:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // send_ack, ack_value, own_seq_out, deliver_payload, conn_state_out,
    // state_changed, rtt_out, rtt_var_out, 2 zero bits
    output logic [utp_rsm_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_wdata
);

    logic                 hdr_valid;
    utp_rsm_pkg::t_hdr    hdr;
    logic                 core_ready;
    utp_rsm_pkg::t_result res;

    utp_rsm_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .o_valid  (hdr_valid),
        .o_item   (hdr),
        .i_take   (core_ready)
    );

    utp_rsm_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (hdr_valid),
        .i_item      (hdr),
        .o_ready     (core_ready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, res};

endmodule

FILE: tb/utp_rsm_checker.sv
module utp_rsm_checker
    import utp_rsm_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [3:0]           i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        CS_IDLE      = 3'd0,
        CS_SYN_SENT  = 3'd1,
        CS_SYN_RECV  = 3'd2,
        CS_CONNECTED = 3'd3,
        CS_CLOSED    = 3'd4
    } conn_state_e;

    logic [15:0] peer_cid;
    logic        initiator;
    logic [15:0] start_seq;

    conn_state_e conn;
    logic [15:0] ack_num;
    logic [15:0] own_seq;
    logic [31:0] rtt_est;
    logic [31:0] rtt_var;

    t_result expected_results[$];
    int      fails = 0;

    function automatic void restart_conn();
        conn    = initiator ? CS_SYN_SENT : CS_IDLE;
        ack_num = '0;
        own_seq = start_seq;
        rtt_est = RTT_INIT;
        rtt_var = RTT_VAR_INIT;
    endfunction

    function automatic t_result step_conn(logic [3:0] typ, logic [S_TDATA_W-1:0] d);
        logic [15:0] len, cid, seq, seq_next;
        logic [31:0] ts, tdiff, now_us, sample, diff, mag, acc;
        t_result     r;
        r      = '0;
        len    = d[15:0];
        cid    = d[31:16];
        seq    = d[47:32];
        ts     = d[79:48];
        tdiff  = d[111:80];
        now_us = d[143:112];
        if (len >= MIN_PKT_LEN) begin
            if (typ == PKT_RESET) begin
                conn            = CS_CLOSED;
                r.state_changed = 1'b1;
            end else if (len >= HEADER_BYTES && cid == peer_cid) begin
                case (typ)
                    PKT_SYN: begin
                        if (conn == CS_IDLE) begin
                            ack_num         = seq;
                            conn            = CS_SYN_RECV;
                            r.send_ack      = 1'b1;
                            r.state_changed = 1'b1;
                        end
                    end
                    PKT_STATE: begin
                        case (conn)
                            CS_SYN_SENT: begin
                                ack_num         = seq;
                                own_seq         = own_seq + 16'd1;
                                conn            = CS_CONNECTED;
                                r.state_changed = 1'b1;
                            end
                            CS_SYN_RECV: begin
                                ack_num         = seq;
                                conn            = CS_CONNECTED;
                                r.state_changed = 1'b1;
                            end
                            CS_CONNECTED: begin
                                if (seq > ack_num) ack_num = seq;
                            end
                            default: ;
                        endcase
                        // RTT sample in every state, 32-bit wrap throughout
                        if (tdiff != 0 && now_us > ts) begin
                            sample = now_us - ts + tdiff;
                            if (rtt_est == RTT_INIT) begin
                                rtt_est = sample;
                                rtt_var = sample >> 1;
                            end else begin
                                diff    = rtt_est - sample;
                                mag     = diff[31] ? -diff : diff;
                                acc     = rtt_var * 32'd3 + mag;
                                rtt_var = acc >> 2;
                                acc     = rtt_est * 32'd7 + sample;
                                rtt_est = acc >> 3;
                            end
                        end
                    end
                    PKT_DATA: begin
                        if (conn == CS_CONNECTED || conn == CS_SYN_RECV) begin
                            seq_next = ack_num + 16'd1;
                            if (seq == seq_next) begin
                                ack_num           = seq;
                                r.deliver         = (len > HEADER_BYTES);
                                if (conn == CS_SYN_RECV) begin
                                    conn            = CS_CONNECTED;
                                    r.state_changed = 1'b1;
                                end
                                r.send_ack        = 1'b1;
                            end else if (seq <= ack_num) begin
                                r.send_ack = 1'b1;
                            end
                        end
                    end
                    PKT_FIN: begin
                        conn            = CS_CLOSED;
                        r.state_changed = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        r.ack_value  = ack_num;
        r.own_seq    = own_seq;
        r.conn_state = conn;
        r.rtt        = rtt_est;
        r.rtt_var    = rtt_var;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            peer_cid  = '0;
            initiator = 1'b0;
            start_seq = '0;
            restart_conn();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CONN_ID: peer_cid = i_cfg_wdata;
                    CFG_OPEN_MODE: begin
                        initiator = i_cfg_wdata[0];
                        restart_conn();
                    end
                    CFG_INIT_SEQ: begin
                        start_seq = i_cfg_wdata;
                        restart_conn();
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_result)-1:0];
                if (expected_results.size() == 0) begin
                    $error("result transfer with no packet outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("send_ack", want.send_ack, got.send_ack);
                    check_field("ack_value", want.ack_value, got.ack_value);
                    check_field("own_seq_out", want.own_seq, got.own_seq);
                    check_field("deliver_payload", want.deliver, got.deliver);
                    check_field("conn_state_out", want.conn_state, got.conn_state);
                    check_field("state_changed", want.state_changed, got.state_changed);
                    check_field("rtt_out", want.rtt, got.rtt);
                    check_field("rtt_var_out", want.rtt_var, got.rtt_var);
                    check_field("pad", '0, i_m_tdata[M_TDATA_W-1:$bits(t_result)]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(step_conn(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: tb/tb_utp_receive_state_machine_unit.sv
module tb_utp_receive_state_machine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utp_rsm_pkg::*;

    localparam int unsigned HDR_BYTES = 20;
    localparam logic [3:0]  PKT_OTHER = 4'd9;
    localparam logic [1:0]  CFG_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [3:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;

    int fail_count;
    int pending;

    bit gap_en = 1'b0;
    bit stall_en = 1'b0;
    int stall_left = 0;

    logic [15:0] cur_cid;
    logic [15:0] peer_seq;
    bit          cur_mode;
    int          n_items = 0;
    int          n_directed = 0;
    int          n_sessions = 0;
    int          n_writes = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utp_receive_state_machine_unit #(
        .HEADER_BYTES(HDR_BYTES)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    utp_rsm_checker #(
        .HEADER_BYTES(HDR_BYTES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver backpressure in bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_hdr(logic [3:0] typ, logic [15:0] len, logic [15:0] cid,
                            logic [15:0] seq, logic [31:0] ts, logic [31:0] tdiff,
                            logic [31:0] now_us);
        if (gap_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= typ;
        s_tdata  <= {now_us, tdiff, ts, seq, cid, len};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        n_writes++;
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'(HDR_BYTES);
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(HDR_BYTES + 1, 1500));
    endfunction

    function automatic logic [3:0] pick_id_type();
        logic [3:0] t;
        t = 4'($urandom_range(0, 3));
        return (t == PKT_RESET) ? PKT_SYN : t;
    endfunction

    task automatic start_session(int k);
        logic [15:0] iseq;
        wait_drained();
        case (k % 4)
            0: cur_cid = 16'h0000;
            1: cur_cid = 16'hFFFF;
            default: cur_cid = 16'($urandom);
        endcase
        case (k % 3)
            0: iseq = 16'hFFFF;
            1: iseq = 16'h0000;
            default: iseq = 16'($urandom);
        endcase
        cur_mode = $urandom_range(0, 1);
        cfg_write(CFG_CONN_ID, cur_cid);
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, 16'($urandom));
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_OPEN_MODE, {15'($urandom), cur_mode});
            cfg_write(CFG_INIT_SEQ, iseq);
        end else begin
            cfg_write(CFG_INIT_SEQ, iseq);
            cfg_write(CFG_OPEN_MODE, {15'($urandom), cur_mode});
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_session(int n_pkts);
        int          r;
        logic [15:0] seq;
        logic [31:0] ts, tdiff, now_us;
        peer_seq = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                               : 16'($urandom);
        // handshake, occasionally skipped
        if ($urandom_range(0, 7) != 0) begin
            if (cur_mode)
                send_hdr(PKT_STATE, pick_len(), cur_cid, peer_seq, $urandom,
                         $urandom_range(0, 1000), $urandom);
            else
                send_hdr(PKT_SYN, pick_len(), cur_cid, peer_seq, $urandom, $urandom,
                         $urandom);
        end
        for (int i = 0; i < n_pkts; i++) begin
            r      = $urandom_range(0, 99);
            ts     = $urandom;
            now_us = ($urandom_range(0, 7) == 0) ? $urandom : ts + $urandom_range(0, 300000);
            tdiff  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 100000);
            if (r < 50) begin
                peer_seq = peer_seq + 16'd1;
                send_hdr(PKT_DATA, pick_len(), cur_cid, peer_seq, ts, tdiff, now_us);
            end else if (r < 60) begin
                seq = peer_seq - 16'($urandom_range(0, 4));
                send_hdr(PKT_DATA, pick_len(), cur_cid, seq, ts, tdiff, now_us);
            end else if (r < 65) begin
                seq = peer_seq + 16'($urandom_range(2, 10));
                send_hdr(PKT_DATA, pick_len(), cur_cid, seq, ts, tdiff, now_us);
            end else if (r < 80) begin
                seq = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : peer_seq + 16'($urandom_range(0, 3));
                send_hdr(PKT_STATE, pick_len(), cur_cid, seq, ts, tdiff, now_us);
            end else if (r < 85) begin
                send_hdr(pick_id_type(), pick_len(), cur_cid ^ 16'($urandom_range(1, 65535)),
                         peer_seq + 16'd1, ts, tdiff, now_us);
            end else if (r < 88) begin
                send_hdr(pick_id_type(), 16'($urandom_range(0, HDR_BYTES - 1)), cur_cid,
                         peer_seq + 16'd1, ts, tdiff, now_us);
            end else if (r < 91) begin
                send_hdr(4'($urandom_range(5, 15)), pick_len(), cur_cid, peer_seq + 16'd1,
                         ts, tdiff, now_us);
            end else if (r < 94) begin
                send_hdr(PKT_SYN, pick_len(), cur_cid, 16'($urandom), ts, tdiff, now_us);
            end else begin
                send_hdr(4'($urandom), 16'($urandom),
                         ($urandom_range(0, 1) == 0) ? cur_cid : 16'($urandom),
                         16'($urandom), $urandom, $urandom, $urandom);
            end
        end
        // teardown
        case ($urandom_range(0, 3))
            0: send_hdr(PKT_FIN, pick_len(), cur_cid, peer_seq + 16'd1, $urandom, 0, 0);
            1: send_hdr(PKT_RESET, 16'($urandom_range(4, 40)), 16'($urandom), 16'($urandom),
                        $urandom, $urandom, $urandom);
            default: ;
        endcase
        repeat ($urandom_range(0, 2))
            send_hdr(PKT_DATA, pick_len(), cur_cid, peer_seq + 16'd1, $urandom, 0, 0);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // listen mode, conn id 0 after reset
        send_hdr(PKT_SYN, 16'd3, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_RESET, 16'd3, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_SYN, 16'd19, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_SYN, 16'd20, 16'd1, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_OTHER, 16'hFFFF, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_STATE, 16'd20, 16'd0, 16'd0, 32'd100, 32'd50, 32'd1100);
        // difference of exactly 2^31 against the estimate
        send_hdr(PKT_STATE, 16'd20, 16'd0, 16'd0, 32'd0, 32'd1, 32'h8000_0000 + 32'd1049);
        send_hdr(PKT_SYN, 16'd20, 16'd0, 16'hFFFE, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_SYN, 16'd20, 16'd0, 16'h1234, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_DATA, 16'd20, 16'd0, 16'hFFFF, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_DATA, 16'd1500, 16'd0, 16'h0000, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_DATA, 16'hFFFF, 16'd0, 16'h0000, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_DATA, 16'd100, 16'd0, 16'd7, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_STATE, 16'd20, 16'd0, 16'hFFFF, 32'd5, 32'd9, 32'd5);
        send_hdr(PKT_STATE, 16'd20, 16'd0, 16'd3, 32'd5, 32'd0, 32'd900);
        send_hdr(PKT_STATE, 16'd20, 16'd0, 16'd3, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_hdr(PKT_DATA, 16'd21, 16'd0, 16'h0000, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_FIN, 16'd20, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_FIN, 16'd20, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_DATA, 16'd50, 16'd0, 16'd1, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_RESET, 16'd4, 16'hFFFF, 16'd0, 32'd0, 32'd0, 32'd0);

        // initiator with own seq about to wrap
        wait_drained();
        cfg_write(CFG_CONN_ID, 16'hFFFF);
        cfg_write(CFG_INIT_SEQ, 16'hFFFF);
        cfg_write(CFG_OPEN_MODE, 16'd1);
        cfg_we <= 1'b0;
        send_hdr(PKT_DATA, 16'd40, 16'hFFFF, 16'd1, 32'd0, 32'd0, 32'd0);
        send_hdr(PKT_STATE, 16'd20, 16'hFFFF, 16'd1234, 32'd10, 32'd0, 32'd20);
        send_hdr(PKT_DATA, 16'd20, 16'hFFFF, 16'd1235, 32'd0, 32'd0, 32'd0);
        n_directed = n_items;

        while (n_items < 900 + n_directed) begin
            start_session(n_sessions);
            if (n_items > 750) begin
                gap_en   = 1'b0;
                stall_en <= 1'b0;
            end else begin
                gap_en   = ($urandom_range(0, 3) != 0);
                stall_en <= ($urandom_range(0, 3) != 0);
            end
            run_session($urandom_range(20, 60));
            n_sessions++;
        end

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Sent %0d packet headers: %0d directed, the rest in %0d random sessions",
                 n_items, n_directed, n_sessions);
        $display("%0d register writes across both open modes and extreme ids and seqs",
                 n_writes);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/utp_rsm_pkg.sv
sv/utp_rsm_in_stage.sv
sv/utp_rsm_core.sv
sv/utp_receive_state_machine_unit.sv
tb/utp_rsm_checker.sv
tb/tb_utp_receive_state_machine_unit.sv
